// ===== hdl/mtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared widths, weights, activation table and fixed-point helpers of the
// tilt controller.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int HIDDEN_UNITS    = 4;
  localparam int OUTPUT_UNITS    = 2;
  localparam int ACT_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(ACT_TABLE_DEPTH);

  // serial multiplier: multiplicand, multiplier and product widths
  localparam int A_W   = 33;
  localparam int B_W   = 18;
  localparam int P_W   = 51;
  localparam int CNT_W = $clog2(B_W);

  typedef struct packed {
    logic                  start;
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [P_W-1:0] prod;
  } mul_rsp_t;

  localparam logic signed [15:0] HID_W [HIDDEN_UNITS][4] = '{
    '{-16'sd1081,  16'sd727, -16'sd4292,  16'sd1250},
    '{ -16'sd403,  16'sd685,  16'sd3508,  16'sd5794},
    '{ -16'sd274,   16'sd81,  -16'sd652,  -16'sd229},
    '{ 16'sd1537, -16'sd358, -16'sd2021, -16'sd2331}
  };

  localparam logic signed [15:0] OUT_W [OUTPUT_UNITS][HIDDEN_UNITS] = '{
    '{-16'sd1521, 16'sd1477,  16'sd836, 16'sd2523},
    '{  16'sd151, 16'sd2120, -16'sd443,  16'sd673}
  };

  typedef logic [12:0] tab_t [ACT_TABLE_DEPTH];

  // restoring long division, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(2.5x) table over |x| in [0, 2), built from a series for exp
  function automatic tab_t build_tab();
    tab_t               t;
    logic        [63:0] one;
    logic        [63:0] num;
    logic        [63:0] den;
    logic        [63:0] term;
    logic        [63:0] p;
    logic signed [63:0] sum;
    one = 64'd1 << 30;
    for (int i = 0; i < ACT_TABLE_DEPTH; i++) begin
      num  = 64'(10 * i);
      den  = 64'(8 * ACT_TABLE_DEPTH);
      term = one;
      sum  = $signed(one);
      for (int k = 1; k <= 30; k++) begin
        term = udiv64(term * num, den * 64'(k));
        if ((k & 1) != 0) sum = sum - $signed(term);
        else              sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      p = $unsigned(sum);
      if (p > one) p = one;
      for (int r = 0; r < 3; r++) begin
        p = (p * p + (one >> 1)) >> 30;
      end
      if (p > one) p = one;
      t[i] = 13'(udiv64((one - p) * 64'd8192 + (one + p), 64'd2 * (one + p)));
    end
    return t;
  endfunction

  localparam tab_t TANH_TAB = build_tab();

  function automatic logic signed [15:0] sat16(input logic signed [P_W-1:0] v);
    logic signed [15:0] r;
    if ((&v[P_W-1:15]) || !(|v[P_W-1:15])) r = v[15:0];
    else if (v[P_W-1])                        r = 16'sh8000;
    else                                      r = 16'sh7fff;
    return r;
  endfunction

  // add half an LSB, floor, saturate
  function automatic logic signed [15:0] rnd_sat(input logic signed [P_W-1:0] v,
                                                 input int unsigned s);
    logic signed [P_W-1:0] half;
    logic signed [P_W-1:0] r;
    half = P_W'(1) << (s - 1);
    r    = (v + half) >>> s;
    return sat16(r);
  endfunction

  function automatic logic signed [15:0] act_tanh(input logic signed [15:0] h);
    logic        [16:0] mag;
    logic        [29:0] idx_full;
    logic signed [15:0] v;
    mag      = h[15] ? 17'(-18'(h)) : 17'(h);
    idx_full = (30'(mag) * 30'(ACT_TABLE_DEPTH)) >> 13;
    if (idx_full >= 30'(ACT_TABLE_DEPTH)) v = 16'sd4096;
    else                                  v = $signed({3'b000, TANH_TAB[idx_full[IDX_W-1:0]]});
    return h[15] ? -v : v;
  endfunction

endpackage

// ===== hdl/mtc_serial_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_serial_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, the top bit
// weighted negative.
// ----------------------------------------------------------------------------
module mtc_serial_mul
  import mtc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [P_W-1:0] mcand_q, mcand_d;
  logic signed [B_W-1:0] mplier_q, mplier_d;
  logic signed [P_W-1:0] acc_q, acc_d;
  logic                  last;
  logic signed [P_W-1:0] addend;

  assign last   = (cnt_q == CNT_W'(B_W - 1));
  assign addend = mplier_q[0] ? (last ? -mcand_q : mcand_q) : '0;

  always_comb begin
    run_d    = run_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (req_i.start) begin
      run_d    = 1'b1;
      cnt_d    = '0;
      mcand_d  = P_W'(req_i.a);
      mplier_d = req_i.b;
      acc_d    = '0;
    end else if (run_q) begin
      acc_d    = acc_q + addend;
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >>> 1;
      cnt_d    = cnt_q + CNT_W'(1);
      if (last) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

// ===== hdl/mlp_tilt_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_tilt_controller_unit
// Fixed-weight 4-4-2 perceptron turning a ball position into two tilt angles.
// ----------------------------------------------------------------------------
// One word in gives one word out. A word with the ball missing yields zero
// angles without any multiplication. A found ball runs 34 multiplications
// in order on one bit-serial multiplier, so the multiplier sets the time a
// word takes. A new word is taken as soon as the sequencer is idle, even
// while the last result still waits in the output register.
module mlp_tilt_controller_unit
  import mtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // x_coord[11:0], y_coord[23:12]
  input  logic        s_axis_tuser_i,  // ball_found[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // inner_angle[15:0], outer_angle[31:16]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    REG_IHW  = 2'd0,
    REG_IHH  = 2'd1,
    REG_GAIN = 2'd2,
    REG_MAX  = 2'd3
  } reg_e;

  // sequence of multiplications
  localparam logic [5:0] STEP_PX    = 6'd0;
  localparam logic [5:0] STEP_PY    = 6'd1;
  localparam logic [5:0] STEP_VX    = 6'd2;
  localparam logic [5:0] STEP_VY    = 6'd3;
  localparam logic [5:0] STEP_HID   = 6'd4;
  localparam logic [5:0] STEP_SQ2   = 6'd20;
  localparam logic [5:0] STEP_CUBE2 = 6'd21;
  localparam logic [5:0] STEP_SQ3   = 6'd22;
  localparam logic [5:0] STEP_CUBE3 = 6'd23;
  localparam logic [5:0] STEP_OUT   = 6'd24;
  localparam logic [5:0] STEP_INNER = 6'd32;
  localparam logic [5:0] STEP_OUTER = 6'd33;

  state_e state_q, state_d;
  logic [5:0] step_q, step_d;

  logic [15:0] ihw_q, ihh_q, gain_q;
  logic [14:0] max_q;

  logic signed [11:0] prev_x_q, prev_y_q;
  logic               first_q, first_d;
  logic signed [11:0] x_q, y_q;
  logic signed [12:0] dx_q, dy_q;

  logic signed [15:0] net_q [4];
  logic signed [15:0] hid_q [HIDDEN_UNITS];
  logic signed [15:0] hpre_q [2];
  logic signed [15:0] o_q [OUTPUT_UNITS];
  logic signed [A_W-1:0] sq_q;
  logic signed [P_W-1:0] acc_q;
  logic signed [15:0] inner_q;

  logic        out_valid_q;
  logic [31:0] out_data_q;

  mul_req_t req;
  mul_rsp_t rsp;

  logic               in_acc;
  logic               slot_free;
  logic signed [11:0] in_x, in_y;
  logic [5:0]         rel;
  logic [1:0]         grp, sel;
  logic signed [P_W-1:0] acc_nxt;
  logic signed [15:0] dot;

  assign in_x      = $signed(s_axis_tdata_i[11:0]);
  assign in_y      = $signed(s_axis_tdata_i[23:12]);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // hidden and output dot products: group (unit) and term within the group
  assign rel     = (step_q >= STEP_OUT) ? step_q - STEP_OUT : step_q - STEP_HID;
  assign grp     = rel[3:2];
  assign sel     = rel[1:0];
  assign acc_nxt = (sel == 2'd0) ? rsp.prod : acc_q + rsp.prod;
  assign dot     = rnd_sat(acc_nxt, 12);

  mtc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // operand selection for the current step
  always_comb begin
    req.start = (state_q == ST_LOAD);
    req.a     = '0;
    req.b     = '0;
    if (step_q == STEP_PX) begin
      req.a = A_W'(x_q);
      req.b = {2'b00, ihw_q};
    end else if (step_q == STEP_PY) begin
      req.a = A_W'(y_q);
      req.b = {2'b00, ihh_q};
    end else if (step_q == STEP_VX) begin
      req.a = A_W'(dx_q);
      req.b = {2'b00, gain_q};
    end else if (step_q == STEP_VY) begin
      req.a = A_W'(dy_q);
      req.b = {2'b00, gain_q};
    end else if (step_q < STEP_SQ2) begin
      req.a = A_W'(net_q[sel]);
      req.b = B_W'(HID_W[grp][sel]);
    end else if (step_q == STEP_SQ2) begin
      req.a = A_W'(hpre_q[0]);
      req.b = B_W'(hpre_q[0]);
    end else if (step_q == STEP_CUBE2) begin
      req.a = sq_q;
      req.b = B_W'(hpre_q[0]);
    end else if (step_q == STEP_SQ3) begin
      req.a = A_W'(hpre_q[1]);
      req.b = B_W'(hpre_q[1]);
    end else if (step_q == STEP_CUBE3) begin
      req.a = sq_q;
      req.b = B_W'(hpre_q[1]);
    end else if (step_q < STEP_INNER) begin
      req.a = A_W'(hid_q[sel]);
      req.b = B_W'(OUT_W[grp[0]][sel]);
    end else if (step_q == STEP_INNER) begin
      req.a = A_W'(o_q[0]);
      req.b = {3'b000, max_q};
    end else begin
      req.a = A_W'(o_q[1]);
      req.b = {3'b000, max_q};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    first_d = first_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          first_d = !s_axis_tuser_i;
          step_d  = STEP_PX;
          state_d = s_axis_tuser_i ? ST_LOAD : ST_EMIT;
        end
      end
      ST_LOAD: state_d = ST_WAIT;
      ST_WAIT: begin
        if (rsp.done) begin
          if (step_q == STEP_OUTER) begin
            state_d = ST_EMIT;
          end else begin
            step_d  = step_q + 6'd1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_PX;
      first_q     <= 1'b1;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      ihw_q       <= 16'd512;
      ihh_q       <= 16'd512;
      gain_q      <= 16'd256;
      max_q       <= 15'd4096;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      first_q <= first_d;
      if (in_acc && s_axis_tuser_i) begin
        prev_x_q <= in_x;
        prev_y_q <= in_y;
      end
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_IHW:  ihw_q  <= cfg_wdata_i;
          REG_IHH:  ihh_q  <= cfg_wdata_i;
          REG_GAIN: gain_q <= cfg_wdata_i;
          REG_MAX:  max_q  <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      // load on emit, drop once the word is taken
      out_valid_q <= (state_q == ST_EMIT && slot_free) || (out_valid_q && !m_axis_tready_i);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q     <= in_x;
      y_q     <= in_y;
      // velocity: new minus stored position, or the negated position on a first sample
      dx_q    <= first_q ? -13'(in_x) : 13'(in_x) - 13'(prev_x_q);
      dy_q    <= first_q ? -13'(in_y) : 13'(in_y) - 13'(prev_y_q);
      inner_q <= '0;
      o_q[1]  <= '0;
    end
    if (state_q == ST_WAIT && rsp.done) begin
      if (step_q == STEP_PX) begin
        net_q[0] <= rnd_sat(rsp.prod, 4);
      end else if (step_q == STEP_PY) begin
        net_q[1] <= rnd_sat(rsp.prod, 4);
      end else if (step_q == STEP_VX) begin
        net_q[2] <= sat16(rsp.prod <<< 4);
      end else if (step_q == STEP_VY) begin
        net_q[3] <= sat16(rsp.prod <<< 4);
      end else if (step_q < STEP_SQ2) begin
        acc_q <= acc_nxt;
        if (sel == 2'd3) begin
          if (!grp[1]) hid_q[grp] <= act_tanh(dot);
          else         hpre_q[grp[0]] <= dot;
        end
      end else if (step_q == STEP_SQ2 || step_q == STEP_SQ3) begin
        sq_q <= rsp.prod[A_W-1:0];
      end else if (step_q == STEP_CUBE2) begin
        hid_q[2] <= rnd_sat(rsp.prod, 24);
      end else if (step_q == STEP_CUBE3) begin
        hid_q[3] <= rnd_sat(rsp.prod, 24);
      end else if (step_q < STEP_INNER) begin
        acc_q <= acc_nxt;
        if (sel == 2'd3) o_q[grp[0]] <= dot;
      end else if (step_q == STEP_INNER) begin
        inner_q <= rnd_sat(-rsp.prod, 12);
      end else begin
        // hold the outer angle in the spent o_q[1] slot until the word leaves
        o_q[1] <= rnd_sat(rsp.prod, 12);
      end
    end
    if (state_q == ST_EMIT && slot_free) begin
      out_data_q <= {o_q[1], inner_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == ST_WAIT)
    else $error("multiplier finished outside the wait state");

  a_load_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |=> state_q == ST_WAIT)
    else $error("load not followed by wait");

  a_missing_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser_i) |=> state_q == ST_EMIT)
    else $error("missing ball did not go straight to emit");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_OUTER)
    else $error("step counter out of range");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && slot_free) |=> m_axis_tvalid_o)
    else $error("result word not presented");
`endif

endmodule

// ===== dv/tb_mlp_tilt_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mlp_tilt_controller_unit
// Self-checking bench for the tilt controller: random and directed ball
// positions, a bit-exact angle predictor, a scoreboard of expected angle pairs.
// ----------------------------------------------------------------------------
module tb_mlp_tilt_controller_unit;
  import mtc_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int TAB_DEPTH  = 256;

  typedef enum logic [1:0] {
    REG_INV_HALF_WIDTH  = 2'd0,
    REG_INV_HALF_HEIGHT = 2'd1,
    REG_VELOCITY_GAIN   = 2'd2,
    REG_MAX_ANGLE       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              found;
    logic signed [11:0] x;
    logic signed [11:0] y;
  } pos_word_t;

  // outer angle in the upper half, inner angle in the lower half
  typedef struct packed {
    logic signed [15:0] outer;
    logic signed [15:0] inner;
  } tilt_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  mlp_tilt_controller_unit DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state and register shadows
  longint   prev_x, prev_y;
  bit       first_pos;
  longint   x_scale, y_scale, vel_gain, angle_max;
  int       tanh_lut [TAB_DEPTH];

  pos_word_t  pos_queue [$];
  tilt_word_t tilt_expect [$];
  int  mismatches = 0;
  int  words_in = 0, words_out = 0;
  bit  quiet = 1'b0;      // no idling in the final stretch
  bit  stim_done = 1'b0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;       // arithmetic shift is floor
  endfunction

  function automatic longint round_sh(longint v, int s);
    return floor_sh(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // exp series, cubed squaring, then (1-e)/(1+e) in Q12
  task automatic fill_tanh_lut();
    longint unsigned one, num, den, term, p;
    longint          sum;
    one = 64'd1 << 30;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      num  = 10 * i;
      den  = 8 * TAB_DEPTH;
      term = one;
      sum  = one;
      for (int k = 1; k <= 30; k++) begin
        term = term * num / (den * k);
        if (k & 1) sum -= longint'(term); else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      p = sum;
      if (p > one) p = one;
      for (int r = 0; r < 3; r++) p = (p * p + (one >> 1)) >> 30;
      if (p > one) p = one;
      tanh_lut[i] = int'(((one - p) * 8192 + (one + p)) / (2 * (one + p)));
    end
  endtask

  function automatic longint squash(longint h);
    longint mag, idx, v;
    mag = (h < 0) ? -h : h;
    idx = (mag * TAB_DEPTH) >>> 13;
    v   = (idx >= TAB_DEPTH) ? 4096 : tanh_lut[idx];
    return (h < 0) ? -v : v;
  endfunction

  function automatic longint hid_weight(int i, int j);
    return longint'(HID_W[i][j]);
  endfunction

  // work out the angle pair for one position word and advance the state
  task automatic predict_tilt(input pos_word_t w);
    longint     nin [4];
    longint     hid [4];
    longint     o [2];
    longint     x, y, dx, dy, acc;
    tilt_word_t t;
    if (!w.found) begin
      first_pos = 1'b1;
      t = '0;
    end else begin
      x  = w.x;
      y  = w.y;
      dx = first_pos ? -x : x - prev_x;
      dy = first_pos ? -y : y - prev_y;
      nin[0] = clip16(round_sh(x * x_scale, 4));
      nin[1] = clip16(round_sh(y * y_scale, 4));
      nin[2] = clip16(dx * vel_gain * 16);
      nin[3] = clip16(dy * vel_gain * 16);
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) acc += hid_weight(i, j) * nin[j];
        acc = clip16(round_sh(acc, 12));
        hid[i] = (i < 2) ? squash(acc) : clip16(round_sh(acc * acc * acc, 24));
      end
      for (int i = 0; i < 2; i++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) acc += longint'(OUT_W[i][j]) * hid[j];
        o[i] = clip16(round_sh(acc, 12));
      end
      prev_x    = x;
      prev_y    = y;
      first_pos = 1'b0;
      t.inner = 16'(clip16(round_sh(-(o[0] * angle_max), 12)));
      t.outer = 16'(clip16(round_sh(o[1] * angle_max, 12)));
    end
    tilt_expect.push_back(t);
  endtask

  // handshake seen at the rising edge, so the driver knows to advance
  bit acc_in = 1'b0;

  // driver: present words from the queue at the falling edge, idle in bursts
  int src_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || acc_in) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pos_queue.size() > 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= pos_queue[0].found;
          s_axis_tdata_i  <= {pos_queue[0].y, pos_queue[0].x};
          if (!quiet && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 5);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    acc_in <= 1'b0;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      acc_in <= 1'b1;
      predict_tilt(pos_queue.pop_front());
      words_in++;
    end
  end

  // sink back-pressure, in bursts
  int snk_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) snk_gap <= $urandom_range(1, 5);
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    tilt_word_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      words_out++;
      if (tilt_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata_o);
      end else begin
        want = tilt_expect.pop_front();
        if (got.inner !== want.inner || got.outer !== want.outer) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: inner exp %0d got %0d, outer exp %0d got %0d",
                     want.inner, got.inner, want.outer, got.outer);
        end
      end
    end
  end

  // watchdog: cycles with no accepted word on either side
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e r, input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (r)
      REG_INV_HALF_WIDTH:  x_scale   = v;
      REG_INV_HALF_HEIGHT: y_scale   = v;
      REG_VELOCITY_GAIN:   vel_gain  = v;
      REG_MAX_ANGLE:       angle_max = v[14:0];
    endcase
  endtask

  // wait for the scoreboard to drain, then a pause for the sequencer
  task automatic drain();
    while (pos_queue.size() > 0 || tilt_expect.size() > 0 || s_axis_tvalid_i)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic pos_word_t rnd_pos(int spread);
    pos_word_t w;
    w.found = ($urandom_range(0, 15) != 0);
    if (spread == 0) begin
      w.x = 12'($urandom);
      w.y = 12'($urandom);
    end else begin
      w.x = 12'($signed($urandom_range(0, 2 * spread)) - spread);
      w.y = 12'($signed($urandom_range(0, 2 * spread)) - spread);
    end
    return w;
  endfunction

  task automatic push_pos(input bit f, input int x, input int y);
    pos_word_t w;
    w.found = f;
    w.x = 12'(x);
    w.y = 12'(y);
    pos_queue.push_back(w);
  endtask

  initial begin
    logic [15:0] sets [4][4];
    fill_tanh_lut();
    prev_x = 0; prev_y = 0; first_pos = 1'b1;
    x_scale = 512; y_scale = 512; vel_gain = 256; angle_max = 4096;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: first sample, missing ball, coordinate extremes, saturation
    push_pos(1, 0, 0);
    push_pos(1, 2047, -2048);
    push_pos(1, -2048, 2047);
    push_pos(1, -2048, 2047);
    push_pos(0, 100, 100);
    push_pos(1, 5, -5);
    push_pos(1, 2047, 2047);
    push_pos(1, -2048, -2048);
    push_pos(0, -1, -1);
    push_pos(0, 0, 0);
    push_pos(1, -1, 1);
    push_pos(1, 30, -40);
    drain();

    // register settings: extremes, mid values, reset-like
    sets[0] = '{16'hffff, 16'hffff, 16'hffff, 16'h7fff};
    sets[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    sets[2] = '{16'd300, 16'd700, 16'd40, 16'd9000};
    sets[3] = '{16'd512, 16'd512, 16'd256, 16'd4096};
    for (int s = 0; s < 4; s++) begin
      for (int r = 0; r < 4; r++) write_reg(cfg_reg_e'(r), sets[s][r]);
      for (int n = 0; n < 250; n++) begin
        // mostly positions in a window around the centre (the full range in the last setting), some anywhere
        if ($urandom_range(0, 3) == 0) pos_queue.push_back(rnd_pos(0));
        else pos_queue.push_back(rnd_pos(s == 3 ? 2048 : 200));
        // hold further words until every expected angle pair has come
        if (n == 125) drain();
        if (s == 3 && n == 200) quiet = 1'b1;
      end
      drain();
    end

    $display("covered %0d position words, %0d angle words, four register settings",
             words_in, words_out);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mtc_pkg.sv
hdl/mtc_serial_mul.sv
hdl/mlp_tilt_controller_unit.sv
dv/tb_mlp_tilt_controller_unit.sv
